@@ rtl/utf8d_pkg.sv @@
package utf8d_pkg;

    // replacement character returned on every error
    localparam logic [20:0] REPL_CHAR = 21'h00FFFD;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_ILLEGAL = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_BADCONT = 3'd4;
    localparam logic [2:0] ST_INVALID = 3'd5;

    localparam logic [2:0] MAX_AVAIL = 3'd4;

    // stage 1: window with its usable length and lead decode
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [2:0] avail;
        logic [2:0] need;
        logic [3:1] cont;
    } t_s1;

    // stage 2: classified request with the raw assembled value
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  need;
        logic [2:0]  consumed;
        logic        written;
        logic [2:0]  status;
    } t_s2;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  consumed;
        logic        point_written;
        logic [2:0]  status;
    } t_result;

    // sequence length from the lead byte, zero for an illegal lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7] == 1'b0) begin
            len = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // shortest encoding length of a code point
    function automatic logic [2:0] encoded_length(input logic [20:0] cp);
        logic [2:0] len;
        len = 3'd1 + {2'b00, (cp > 21'h00007F)} + {2'b00, (cp > 21'h0007FF)}
            + {2'b00, (cp > 21'h00FFFF)};
        return len;
    endfunction

endpackage

@@ rtl/utf8d_if.sv @@
interface utf8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [2:0] avail_len;

    modport source (output valid, output byte0, output byte1, output byte2,
                    output byte3, output avail_len, input ready);
    modport sink (input valid, input byte0, input byte1, input byte2,
                  input byte3, input avail_len, output ready);
endinterface

interface utf8d_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  consumed;
    logic        point_written;
    logic [2:0]  status;

    modport source (output valid, output code_point, output consumed,
                    output point_written, output status, input ready);
    modport sink (input valid, input code_point, input consumed,
                  input point_written, input status, output ready);
endinterface

@@ rtl/utf8d_check.sv @@
module utf8d_check (
    input  utf8d_pkg::t_s2     i_s2,
    output utf8d_pkg::t_result o_res
);

    logic       w_too_big;
    logic       w_surrogate;
    logic       w_overlong;

    assign w_too_big   = (i_s2.cp > 21'h10FFFF);
    assign w_surrogate = (i_s2.cp >= 21'h00D800) && (i_s2.cp <= 21'h00DFFF);
    assign w_overlong  = (utf8d_pkg::encoded_length(i_s2.cp) < i_s2.need);

    always_comb begin
        o_res.code_point    = i_s2.cp;
        o_res.consumed      = i_s2.consumed;
        o_res.point_written = i_s2.written;
        o_res.status        = i_s2.status;
        // only a cleanly framed sequence still needs the value checks
        if ((i_s2.status == utf8d_pkg::ST_OK) && (w_too_big || w_surrogate || w_overlong)) begin
            o_res.code_point = utf8d_pkg::REPL_CHAR;
            o_res.consumed   = i_s2.need;
            o_res.status     = utf8d_pkg::ST_INVALID;
        end
    end

endmodule

@@ rtl/utf8_sequence_decoder.sv @@
// utf8 sequence decoder
// i_in carries one request per handshake: a window of four bytes (byte0 is
// the lead byte) and avail_len, the count of usable bytes; zero means the
// count is the position of the first zero byte, and counts above four act
// as four. o_out returns one result per request: the code point (U+FFFD on
// any error), the bytes consumed, point_written and a status code.
// the datapath is a three stage pipeline: length and lead decode, framing
// classification with value assembly, then the range and overlong check
// into the output register. a request accepted into the stage 1 register
// passes through the stage 2 register to the output register and is then
// offered on o_out; one request is taken every cycle while o_out is ready.
// when o_out is stalled each stage holds and a stage takes new data only
// where it is empty or the one ahead takes its contents, so nothing is lost
// or repeated and i_in.ready falls only once all three stages are full.
// i_rst_n is synchronous and active low; it empties the pipeline.
module utf8_sequence_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    utf8d_in_if.sink           i_in,
    utf8d_out_if.source        o_out
);

    // stage valid bits and payload registers
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_v3;
    utf8d_pkg::t_s1       r_s1;
    utf8d_pkg::t_s2       r_s2;
    utf8d_pkg::t_result   r_out;

    utf8d_pkg::t_s1       n_s1;
    utf8d_pkg::t_s2       n_s2;
    utf8d_pkg::t_result   n_out;

    // a stage may load when it is empty or its contents move on
    logic                 w_rdy1;
    logic                 w_rdy2;
    logic                 w_rdy3;

    logic [2:0]           w_bad_pos;

    assign w_rdy3 = !r_v3 || o_out.ready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;

    assign i_in.ready = w_rdy1;

    // stage 1: usable length, lead length and continuation flags
    always_comb begin
        n_s1.b0   = i_in.byte0;
        n_s1.b1   = i_in.byte1;
        n_s1.b2   = i_in.byte2;
        n_s1.b3   = i_in.byte3;
        n_s1.need = utf8d_pkg::lead_length(i_in.byte0);
        n_s1.cont = {(i_in.byte3[7:6] == 2'b10), (i_in.byte2[7:6] == 2'b10),
                     (i_in.byte1[7:6] == 2'b10)};
        if (i_in.avail_len == 3'd0) begin
            // length found from the zero terminator
            if (i_in.byte0 == 8'h00) begin
                n_s1.avail = 3'd0;
            end else if (i_in.byte1 == 8'h00) begin
                n_s1.avail = 3'd1;
            end else if (i_in.byte2 == 8'h00) begin
                n_s1.avail = 3'd2;
            end else if (i_in.byte3 == 8'h00) begin
                n_s1.avail = 3'd3;
            end else begin
                n_s1.avail = utf8d_pkg::MAX_AVAIL;
            end
        end else if (i_in.avail_len > utf8d_pkg::MAX_AVAIL) begin
            n_s1.avail = utf8d_pkg::MAX_AVAIL;
        end else begin
            n_s1.avail = i_in.avail_len;
        end
    end

    // first continuation byte that breaks the sequence, zero if none
    always_comb begin
        w_bad_pos = 3'd0;
        if ((r_s1.need >= 3'd2) && !r_s1.cont[1]) begin
            w_bad_pos = 3'd1;
        end else if ((r_s1.need >= 3'd3) && !r_s1.cont[2]) begin
            w_bad_pos = 3'd2;
        end else if ((r_s1.need == 3'd4) && !r_s1.cont[3]) begin
            w_bad_pos = 3'd3;
        end
    end

    // stage 2: framing errors and value assembly
    always_comb begin
        n_s2.need     = r_s1.need;
        n_s2.written  = 1'b1;
        n_s2.consumed = r_s1.need;
        n_s2.status   = utf8d_pkg::ST_OK;
        unique case (r_s1.need)
            3'd2:    n_s2.cp = {10'd0, r_s1.b0[4:0], r_s1.b1[5:0]};
            3'd3:    n_s2.cp = {5'd0, r_s1.b0[3:0], r_s1.b1[5:0], r_s1.b2[5:0]};
            3'd4:    n_s2.cp = {r_s1.b0[2:0], r_s1.b1[5:0], r_s1.b2[5:0],
                                r_s1.b3[5:0]};
            default: n_s2.cp = {13'd0, r_s1.b0};
        endcase
        if (r_s1.avail == 3'd0) begin
            // empty window writes nothing
            n_s2.cp       = 21'd0;
            n_s2.consumed = 3'd0;
            n_s2.written  = 1'b0;
            n_s2.status   = utf8d_pkg::ST_EMPTY;
        end else if (r_s1.need == 3'd0) begin
            n_s2.cp       = utf8d_pkg::REPL_CHAR;
            n_s2.consumed = 3'd1;
            n_s2.status   = utf8d_pkg::ST_ILLEGAL;
        end else if (r_s1.avail < r_s1.need) begin
            n_s2.cp       = utf8d_pkg::REPL_CHAR;
            n_s2.consumed = r_s1.avail;
            n_s2.status   = utf8d_pkg::ST_TRUNC;
        end else if (w_bad_pos != 3'd0) begin
            n_s2.cp       = utf8d_pkg::REPL_CHAR;
            n_s2.consumed = w_bad_pos;
            n_s2.status   = utf8d_pkg::ST_BADCONT;
        end
    end

    // stage 3: surrogate, range and overlong check
    utf8d_check u_check (
        .i_s2  (r_s2),
        .o_res (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_in.valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_in.valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
        if (w_rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_v3;
    assign o_out.code_point    = r_out.code_point;
    assign o_out.consumed      = r_out.consumed;
    assign o_out.point_written = r_out.point_written;
    assign o_out.status        = r_out.status;

endmodule

@@ rtl/utf8d_chk.sv @@
module utf8d_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic [2:0]  i_consumed,
    input logic        i_point_written,
    input logic [2:0]  i_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_point)
            && $stable(i_consumed) && $stable(i_status))
        else $error("result changed while stalled");

    // only an empty window writes nothing and consumes nothing
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_point_written == (i_status != utf8d_pkg::ST_EMPTY))
            && ((i_consumed == 3'd0) == (i_status == utf8d_pkg::ST_EMPTY)))
        else $error("empty flag mismatch");

    // every error returns the replacement character
    a_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == utf8d_pkg::ST_ILLEGAL
            || i_status == utf8d_pkg::ST_TRUNC || i_status == utf8d_pkg::ST_BADCONT
            || i_status == utf8d_pkg::ST_INVALID) |-> i_code_point == utf8d_pkg::REPL_CHAR)
        else $error("error without replacement character");

    // a good code point is in range and not a surrogate
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == utf8d_pkg::ST_OK) |-> (i_code_point <= 21'h10FFFF)
            && !((i_code_point >= 21'h00D800) && (i_code_point <= 21'h00DFFF))
            && (i_consumed != 3'd0) && (i_consumed <= utf8d_pkg::MAX_AVAIL))
        else $error("bad code point reported ok");

endmodule

bind utf8_sequence_decoder utf8d_chk u_utf8d_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_code_point    (o_out.code_point),
    .i_consumed      (o_out.consumed),
    .i_point_written (o_out.point_written),
    .i_status        (o_out.status)
);
